[hdl/rwcp_pkg.sv]
// Shared types and constants for the RIFF/WAVE chunk parser.
package rwcp_pkg;

  // Parse phases of the chunk walker.
  localparam logic [1:0] PH_RIFF = 2'd0;
  localparam logic [1:0] PH_CHDR = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Four-character tags, first byte in the top bits.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT   = 32'h666D_7420;
  localparam logic [31:0] ID_DATA  = 32'h6461_7461;

  // Number of fmt body bytes a capture reads.
  localparam logic [4:0] FMT_LAST_COUNT = 5'd16;

  // Per-word control from the walker to the fmt capture.
  typedef struct packed {
    logic advance;    // word taken past the file header while it is valid
    logic start_fmt;  // a fmt chunk header just completed
    logic clear;      // final word of the buffer: return to reset values
  } rwcp_step_t;

  // Walker state after the current word, as seen by the result logic.
  typedef struct packed {
    logic        hdr_ok;
    logic        in_riff;
    logic        pay_seen;
    logic [31:0] pay_off;
    logic [31:0] pay_decl;
    logic [31:0] pay_rcv;
  } rwcp_view_t;

  // Byte i of a four-character tag, in stream order.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = tag[31:24];
      2'd1:    b = tag[23:16];
      2'd2:    b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

[hdl/rwcp_in_stage.sv]
// Input register that holds one buffer word ahead of the parse logic.
module rwcp_in_stage
  import rwcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // The register frees up in the same cycle its word is consumed.
  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign held_valid = vld_r;
  assign held_byte  = byte_r;
  assign held_last  = last_r;

endmodule

[hdl/rwcp_walker.sv]
// Header check, chunk header walk, body skip and data chunk tracking.
module rwcp_walker
  import rwcp_pkg::*;
#(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] step_byte,
  input  logic       step_last,
  output rwcp_step_t step,
  output rwcp_view_t view
);

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic                    hdr_ok_r, hdr_ok_nxt;
  logic [31:0]             id_r, id_nxt;
  logic [31:0]             size_r, size_nxt;
  logic [32:0]             body_r, body_nxt;
  logic [2:0]              hcnt_r, hcnt_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;
  logic [31:0]             decl_r, decl_nxt;
  logic [OFFSET_WIDTH-1:0] rcv_r, rcv_nxt;
  logic                    seen_r, seen_nxt;
  logic                    advance, start_fmt;
  logic [1:0]              tag_idx;
  logic [32:0]             body_dec;

  assign tag_idx = pos_r[1:0];

  // Per-word update, written in the order the stream is interpreted.
  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    hdr_ok_nxt = hdr_ok_r;
    id_nxt     = id_r;
    size_nxt   = size_r;
    body_nxt   = body_r;
    hcnt_nxt   = hcnt_r;
    off_nxt    = off_r;
    decl_nxt   = decl_r;
    rcv_nxt    = rcv_r;
    seen_nxt   = seen_r;
    advance    = 1'b0;
    start_fmt  = 1'b0;
    body_dec   = body_r - 33'd1;

    if (step_en) begin
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end

      if (phase_r == PH_RIFF) begin
        // The file header occupies positions 0 to 11, so four bits index it.
        if (pos_r[3:2] == 2'd0 && step_byte != tag_byte(TAG_RIFF, tag_idx)) begin
          hdr_ok_nxt = 1'b0;
        end
        if (pos_r[3:2] == 2'd2 && step_byte != tag_byte(TAG_WAVE, tag_idx)) begin
          hdr_ok_nxt = 1'b0;
        end
        if (pos_r[3:0] >= 4'd11) begin
          phase_nxt = PH_CHDR;
        end
      end else if (hdr_ok_r) begin
        advance = 1'b1;
        if (seen_r && rcv_r != POS_MAX) begin
          rcv_nxt = rcv_r + 1'b1;
        end

        if (phase_r == PH_BODY) begin
          // Skip the body; a nonzero count is kept in this phase.
          if (body_r != 33'd0) begin
            body_nxt = body_dec;
          end
          if (body_nxt == 33'd0) begin
            phase_nxt = PH_CHDR;
          end
        end else begin
          // Four id bytes, then a little-endian size.
          if (!hcnt_r[2]) begin
            id_nxt = {id_r[23:0], step_byte};
          end else begin
            size_nxt = {step_byte, size_r[31:8]};
          end
          hcnt_nxt = hcnt_r + 1'b1;
          if (hcnt_r == 3'd7) begin
            if (id_nxt == ID_FMT) begin
              start_fmt = 1'b1;
            end else if (id_nxt == ID_DATA) begin
              off_nxt  = pos_nxt;
              decl_nxt = size_nxt;
              rcv_nxt  = '0;
              seen_nxt = 1'b1;
            end
            // Odd sizes carry one pad byte.
            body_nxt  = {1'b0, size_nxt} + {32'd0, size_nxt[0]};
            phase_nxt = (body_nxt == 33'd0) ? PH_CHDR : PH_BODY;
          end
        end
      end
    end
  end

  // Values after this word, before the end-of-buffer clear.
  assign view.hdr_ok   = hdr_ok_nxt;
  assign view.in_riff  = (phase_nxt == PH_RIFF);
  assign view.pay_seen = seen_nxt;
  assign view.pay_off  = 32'(off_nxt);
  assign view.pay_decl = decl_nxt;
  assign view.pay_rcv  = 32'(rcv_nxt);

  assign step.advance   = advance;
  assign step.start_fmt = start_fmt;
  assign step.clear     = step_en && step_last;

  // State registers; the final word of a buffer returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step_last)) begin
      pos_r    <= '0;
      phase_r  <= PH_RIFF;
      hdr_ok_r <= 1'b1;
      id_r     <= '0;
      size_r   <= '0;
      body_r   <= '0;
      hcnt_r   <= '0;
      off_r    <= '0;
      decl_r   <= '0;
      rcv_r    <= '0;
      seen_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      id_r     <= id_nxt;
      size_r   <= size_nxt;
      body_r   <= body_nxt;
      hcnt_r   <= hcnt_nxt;
      off_r    <= off_nxt;
      decl_r   <= decl_nxt;
      rcv_r    <= rcv_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // The file header phase never outlives its twelve bytes.
  a_riff_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RIFF |-> pos_r[OFFSET_WIDTH-1:4] == '0 && pos_r[3:0] <= 4'd11)
    else $error("file header phase past position 11");

  // A body phase always has bytes left to skip.
  a_body_nz: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_r != 33'd0)
    else $error("body phase with empty skip count");

  // A partial chunk header only exists in the chunk header phase.
  a_hcnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r != 3'd0 |-> phase_r == PH_CHDR)
    else $error("chunk header count outside header phase");

endmodule

[hdl/rwcp_fmt_capture.sv]
// Two overlapping fmt capture slots and the kept channel count and rate.
module rwcp_fmt_capture
  import rwcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rwcp_step_t  step,
  input  logic [7:0]  step_byte,
  output logic [15:0] kept_channels,
  output logic [31:0] kept_rate
);

  logic [4:0]  cnt_r  [2];
  logic [15:0] ch_r   [2];
  logic [31:0] rate_r [2];
  logic [4:0]  cnt_nxt  [2];
  logic [15:0] ch_nxt   [2];
  logic [31:0] rate_nxt [2];
  logic [15:0] kch_r, kch_upd;
  logic [31:0] krate_r, krate_upd;
  logic [4:0]  k;
  logic        sel;

  always_comb begin
    kch_upd   = kch_r;
    krate_upd = krate_r;
    sel       = 1'b0;
    k         = '0;
    for (int s = 0; s < 2; s++) begin
      cnt_nxt[s]  = cnt_r[s];
      ch_nxt[s]   = ch_r[s];
      rate_nxt[s] = rate_r[s];
    end

    if (step.advance) begin
      // Each armed slot takes the byte at its body offset; slot one wins a tie.
      for (int s = 0; s < 2; s++) begin
        if (cnt_r[s] != 5'd0) begin
          k = cnt_r[s] - 5'd1;
          case (k)
            5'd2:    ch_nxt[s][7:0]     = step_byte;
            5'd3:    ch_nxt[s][15:8]    = step_byte;
            5'd4:    rate_nxt[s][7:0]   = step_byte;
            5'd5:    rate_nxt[s][15:8]  = step_byte;
            5'd6:    rate_nxt[s][23:16] = step_byte;
            5'd7:    rate_nxt[s][31:24] = step_byte;
            default: ;
          endcase
          if (cnt_r[s] >= FMT_LAST_COUNT) begin
            kch_upd    = ch_nxt[s];
            krate_upd  = rate_nxt[s];
            cnt_nxt[s] = '0;
          end else begin
            cnt_nxt[s] = cnt_r[s] + 5'd1;
          end
        end
      end

      // A new capture takes a free slot, else the one further along.
      if (step.start_fmt) begin
        if (cnt_nxt[0] == 5'd0) begin
          sel = 1'b0;
        end else if (cnt_nxt[1] == 5'd0) begin
          sel = 1'b1;
        end else begin
          sel = (cnt_nxt[0] >= cnt_nxt[1]) ? 1'b0 : 1'b1;
        end
        cnt_nxt[sel]  = 5'd1;
        ch_nxt[sel]   = '0;
        rate_nxt[sel] = '0;
      end
    end
  end

  // Kept values include a capture that completes on the final word.
  assign kept_channels = kch_upd;
  assign kept_rate     = krate_upd;

  always_ff @(posedge clk) begin
    if (!rst_n || step.clear) begin
      for (int s = 0; s < 2; s++) begin
        cnt_r[s]  <= '0;
        ch_r[s]   <= '0;
        rate_r[s] <= '0;
      end
      kch_r   <= '0;
      krate_r <= '0;
    end else begin
      for (int s = 0; s < 2; s++) begin
        cnt_r[s]  <= cnt_nxt[s];
        ch_r[s]   <= ch_nxt[s];
        rate_r[s] <= rate_nxt[s];
      end
      kch_r   <= kch_upd;
      krate_r <= krate_upd;
    end
  end

  // Slots advance together, so two armed slots never share a count.
  a_slots_apart: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] != 5'd0 |-> cnt_r[0] != cnt_r[1])
    else $error("fmt capture slots share a count");

endmodule

[hdl/riff_wave_chunk_parser.sv]
// Top level of the RIFF/WAVE chunk parser with its result register.
//
//  Channel   Ports                                    Dir  Meaning
//  in_       valid, ready, data_byte, last_byte       in   one buffer byte per word
//  out_      valid, ready, parse_ok, rate_hz,         out  one summary word per buffer
//            channel_count, data_offset, data_size
//
// Between the input register and the result register one byte is parsed per cycle
// unless a final byte waits; a summary word is registered as its final byte is taken.
// Reset (rst_n low, synchronous) clears all parse state; the parser is ready at once.
// A final byte waits in the input register while an earlier summary word is not
// taken; other bytes keep flowing. After each final byte all parse state restarts.
module riff_wave_chunk_parser
  import rwcp_pkg::*;
#(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_parse_ok,
  output logic [31:0] out_rate_hz,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size
);

  logic        held_valid, held_last, take, slot_free;
  logic [7:0]  held_byte;
  rwcp_step_t  step;
  rwcp_view_t  view;
  logic [15:0] kept_ch;
  logic [31:0] kept_rate;
  logic        fin_ok;
  logic [31:0] dsize;
  logic        out_valid_r;
  logic        ok_r;
  logic [31:0] rate_r, off_r, size_r;
  logic [15:0] ch_r;

  rwcp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .take         (take),
    .held_valid   (held_valid),
    .held_byte    (held_byte),
    .held_last    (held_last)
  );

  // A final byte needs a free result register; any other byte goes straight on.
  assign slot_free = !out_valid_r || out_ready;
  assign take      = held_valid && (!held_last || slot_free);

  rwcp_walker #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (take),
    .step_byte (held_byte),
    .step_last (held_last),
    .step      (step),
    .view      (view)
  );

  rwcp_fmt_capture u_fmt (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .step_byte     (held_byte),
    .kept_channels (kept_ch),
    .kept_rate     (kept_rate)
  );

  // Summary of the buffer; a bad or short file header zeroes every field.
  assign fin_ok = view.hdr_ok && !view.in_riff;
  assign dsize  = !view.pay_seen ? 32'd0 :
                  (view.pay_decl < view.pay_rcv) ? view.pay_decl : view.pay_rcv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && held_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_last) begin
      if (fin_ok) begin
        ok_r   <= kept_rate != 32'd0 && kept_ch != 16'd0 && view.pay_seen && dsize != 32'd0;
        rate_r <= kept_rate;
        ch_r   <= kept_ch;
        off_r  <= view.pay_seen ? view.pay_off : 32'd0;
        size_r <= dsize;
      end else begin
        ok_r   <= 1'b0;
        rate_r <= '0;
        ch_r   <= '0;
        off_r  <= '0;
        size_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_parse_ok      = ok_r;
  assign out_rate_hz       = rate_r;
  assign out_channel_count = ch_r;
  assign out_data_offset   = off_r;
  assign out_data_size     = size_r;

  // A good parse always reports nonzero rate, channels and size.
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ok_r |-> rate_r != 32'd0 && ch_r != 16'd0 && size_r != 32'd0)
    else $error("parse_ok with a zero field");

  // A final byte is never consumed while a summary word is still held.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(take && held_last))
    else $error("summary word overwritten");

endmodule
